// ===== hdl/shu_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 stream hash unit.
// Used by the channel interfaces' users, the round unit and the top level; no dependencies.
package shu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTES,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       load;
        logic       round;
        logic [5:0] round_idx;
    } core_ctrl_t;

    localparam logic [2:0] MAX_BYTES  = 3'd4;
    localparam logic [2:0] LAST_INDEX = 3'd7;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LEN_FILL   = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hdl/shu_msg_if.sv =====
// Message channel: request carrying up to four bytes and an end-of-message flag.
// No dependencies.
interface shu_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        is_last;

    modport source (output valid, output data_word, output byte_count, output is_last,
                    input ready);
    modport sink (input valid, input data_word, input byte_count, input is_last,
                  output ready);
endinterface

// ===== hdl/shu_digest_if.sv =====
// Digest channel: request carrying one 32-bit word of the hash and its position.
// No dependencies.
interface shu_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

// ===== hdl/shu_round_unit.sv =====
// Block buffer, message schedule window and working variables with one SHA-256 round.
// Depends on shu_pkg (control struct, round constants, sigma functions).
module shu_round_unit (
    input  logic                clk,
    input  shu_pkg::core_ctrl_t ctrl,
    input  logic [31:0]         h_in [8],
    output logic [31:0]         v_out [8]
);

    // Bytes shift in at the bottom; after 64 pushes word 0 of the block sits at the top.
    // During rounds the same register is the rolling schedule window W[i..i+15].
    logic [511:0] blk_reg, blk_next;
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];

    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2, ch, maj;

    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];

    assign w_new = shu_pkg::small_sigma1(w14) + w9 + shu_pkg::small_sigma0(w1) + w0;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + shu_pkg::big_sigma1(v_reg[4]) + ch
               + shu_pkg::ROUND_K[ctrl.round_idx] + w0;
    assign t2  = shu_pkg::big_sigma0(v_reg[0]) + maj;

    always_comb
    begin
        blk_next = blk_reg;
        if (ctrl.push)
        begin
            blk_next = {blk_reg[503:0], ctrl.push_data};
        end
        else if (ctrl.round)
        begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_comb
    begin
        v_next = v_reg;
        if (ctrl.load)
        begin
            v_next = h_in;
        end
        else if (ctrl.round)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    // Payload only: no reset needed.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        v_reg   <= v_next;
    end

    assign v_out = v_reg;

endmodule

// ===== hdl/sha256_stream_hash_unit.sv =====
// Top level of the SHA-256 stream hash unit: sequencer, hash state, counters, channels.
// Depends on shu_pkg, shu_msg_if, shu_digest_if and shu_round_unit.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   msg      | in  | valid / ready | data_word[31:0], byte_count[2:0], is_last
//   digest   | out | valid / ready | digest_word[31:0], word_index[2:0], last_word
//
// A request pushes its bytes into the block in turn (byte_count above four counts as four).
// Each block that fills is compressed by 64 rounds through the one round unit, then an
// update of the hash state. A last request adds the padding bytes (a marker, zeros and
// the length field) and one or two compressions, then holds eight digest words until
// they are taken.
// msg.ready is high only while idle; a stalled digest holds the unit in place.
// Reset (asynchronous, active low) loads the standard initial hash and clears counters.
module sha256_stream_hash_unit (
    input  logic                clk,
    input  logic                rst_n,
    shu_msg_if.sink             msg,
    shu_digest_if.source        digest
);

    shu_pkg::state_t     state_reg, state_next;
    shu_pkg::state_t     ret_reg, ret_next;
    shu_pkg::core_ctrl_t ctrl;

    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  left_reg, left_next;
    logic        last_reg, last_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] v_words [8];

    logic       msg_take;
    logic       digest_take;
    logic       push;
    logic [7:0] push_data;
    logic       block_full;
    logic [2:0] sat_count;

    assign msg_take    = msg.valid && msg.ready;
    assign digest_take = digest.valid && digest.ready;
    assign sat_count   = (msg.byte_count > shu_pkg::MAX_BYTES) ? shu_pkg::MAX_BYTES
                                                                : msg.byte_count;

    // Outputs of the sequencer
    always_comb
    begin
        push      = 1'b0;
        push_data = 8'h00;
        case (state_reg)
            shu_pkg::ST_BYTES:
            begin
                push      = (left_reg != 3'd0);
                push_data = word_reg[31:24];
            end
            shu_pkg::ST_PAD_MARK:
            begin
                push      = 1'b1;
                push_data = shu_pkg::PAD_BYTE;
            end
            shu_pkg::ST_PAD_ZERO:
            begin
                push      = (fill_reg != shu_pkg::LEN_FILL);
                push_data = 8'h00;
            end
            shu_pkg::ST_PAD_LEN:
            begin
                push      = 1'b1;
                push_data = bits_reg[63:56];
            end
            default:
            begin
                push      = 1'b0;
                push_data = 8'h00;
            end
        endcase
        block_full     = push && (fill_reg == shu_pkg::LAST_FILL);
        ctrl.push      = push;
        ctrl.push_data = push_data;
        ctrl.load      = block_full;
        ctrl.round     = (state_reg == shu_pkg::ST_ROUND);
        ctrl.round_idx = round_reg;
        msg.ready      = (state_reg == shu_pkg::ST_IDLE);
        digest.valid   = (state_reg == shu_pkg::ST_OUT);
    end

    // Next state and return point after a compression
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            shu_pkg::ST_IDLE:
            begin
                if (msg_take)
                begin
                    state_next = shu_pkg::ST_BYTES;
                end
            end
            shu_pkg::ST_BYTES:
            begin
                if (left_reg != 3'd0)
                begin
                    if (block_full)
                    begin
                        state_next = shu_pkg::ST_ROUND;
                        ret_next   = shu_pkg::ST_BYTES;
                    end
                end
                else if (last_reg)
                begin
                    state_next = shu_pkg::ST_PAD_MARK;
                end
                else
                begin
                    state_next = shu_pkg::ST_IDLE;
                end
            end
            shu_pkg::ST_ROUND:
            begin
                if (round_reg == shu_pkg::LAST_ROUND)
                begin
                    state_next = shu_pkg::ST_UPDATE;
                end
            end
            shu_pkg::ST_UPDATE:
            begin
                state_next = ret_reg;
            end
            shu_pkg::ST_PAD_MARK:
            begin
                state_next = block_full ? shu_pkg::ST_ROUND : shu_pkg::ST_PAD_ZERO;
                ret_next   = shu_pkg::ST_PAD_ZERO;
            end
            shu_pkg::ST_PAD_ZERO:
            begin
                if (fill_reg == shu_pkg::LEN_FILL)
                begin
                    state_next = shu_pkg::ST_PAD_LEN;
                end
                else if (block_full)
                begin
                    state_next = shu_pkg::ST_ROUND;
                    ret_next   = shu_pkg::ST_PAD_ZERO;
                end
            end
            shu_pkg::ST_PAD_LEN:
            begin
                if (block_full)
                begin
                    state_next = shu_pkg::ST_ROUND;
                    ret_next   = shu_pkg::ST_OUT;
                end
            end
            shu_pkg::ST_OUT:
            begin
                if (digest_take && (idx_reg == shu_pkg::LAST_INDEX))
                begin
                    state_next = shu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = shu_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath registers
    always_comb
    begin
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        word_next  = word_reg;
        left_next  = left_reg;
        last_next  = last_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        h_next     = h_reg;

        if (msg_take)
        begin
            word_next = msg.data_word;
            left_next = sat_count;
            last_next = msg.is_last;
            bits_next = bits_reg + (64'(sat_count) << 3);
        end

        if (push)
        begin
            fill_next = fill_reg + 6'd1;
            if (state_reg == shu_pkg::ST_BYTES)
            begin
                word_next = {word_reg[23:0], 8'h00};
                left_next = left_reg - 3'd1;
            end
            if (state_reg == shu_pkg::ST_PAD_LEN)
            begin
                bits_next = {bits_reg[55:0], 8'h00};
            end
        end

        if (state_reg == shu_pkg::ST_ROUND)
        begin
            round_next = round_reg + 6'd1;
        end

        if (state_reg == shu_pkg::ST_UPDATE)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + v_words[i];
            end
        end

        if (digest_take)
        begin
            idx_next = idx_reg + 3'd1;
            // Restart for the next message once the final word has gone
            if (idx_reg == shu_pkg::LAST_INDEX)
            begin
                h_next    = shu_pkg::INIT_H;
                fill_next = 6'd0;
                bits_next = 64'd0;
                last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shu_pkg::ST_IDLE;
            ret_reg   <= shu_pkg::ST_IDLE;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
            left_reg  <= 3'd0;
            last_reg  <= 1'b0;
            round_reg <= 6'd0;
            idx_reg   <= 3'd0;
            h_reg     <= shu_pkg::INIT_H;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            left_reg  <= left_next;
            last_reg  <= last_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    shu_round_unit u_round (
        .clk   (clk),
        .ctrl  (ctrl),
        .h_in  (h_reg),
        .v_out (v_words)
    );

    assign digest.digest_word = h_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == shu_pkg::LAST_INDEX);

endmodule

// ===== hdl/shu_checker.sv =====
// Port-level checks on the SHA-256 stream hash unit, attached by a bind statement.
// Depends on sha256_stream_hash_unit and its two channel interfaces.
module shu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        msg_ready,
    input logic        digest_valid,
    input logic        digest_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // Digest words follow one another in order with no gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && (word_index != 3'd7)) |=>
            (digest_valid && (word_index == 3'($past(word_index) + 3'd1))))
        else $error("digest words out of order");

    // The digest closes after its eighth word
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && last_word) |=> !digest_valid)
        else $error("digest continues past its final word");

    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    // No new message request is taken while a digest is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(msg_ready && digest_valid))
        else $error("message accepted during digest output");

    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_ready) |=> (digest_valid && $stable(digest_word)))
        else $error("stalled digest word changed");

endmodule

bind sha256_stream_hash_unit shu_checker u_shu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_ready    (msg.ready),
    .digest_valid (digest.valid),
    .digest_ready (digest.ready),
    .digest_word  (digest.digest_word),
    .word_index   (digest.word_index),
    .last_word    (digest.last_word)
);
